// File: hdl/jcrd_pkg.sv
// Shared types, constants and the magnitude-extension function for the
// coefficient run decoder. No dependencies.
package jcrd_pkg;

  localparam int BLOCK_COEFS    = 64;
  localparam int NUM_COMPONENTS = 4;
  localparam int POS_W          = $clog2(BLOCK_COEFS);
  localparam int COMP_W         = 2;
  localparam int VAL_W          = 16;
  localparam int BITS_W         = 15;
  localparam int SYM_W          = 8;
  localparam int NIB_W          = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFS - 1);
  localparam logic [NIB_W-1:0] MAX_SIZE = 4'hF;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } jcrd_state_t;

  // How the current item expands into results
  typedef enum logic [1:0] {
    KIND_DC,
    KIND_EOB,
    KIND_OVR,
    KIND_AC
  } jcrd_kind_t;

  typedef struct packed {
    logic load;
    logic emit;
  } jcrd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic step_last;
  } jcrd_sts_t;

  // size-many low bits of raw; below half range means negative value
  function automatic logic [VAL_W-1:0] jcrd_extend(input logic [NIB_W-1:0] size,
                                                   input logic [BITS_W-1:0] raw);
    logic [VAL_W-1:0] span;
    logic [VAL_W-1:0] half;
    logic [VAL_W-1:0] b;
    span = VAL_W'(1) << size;
    half = span >> 1;
    b    = {1'b0, raw} & (span - VAL_W'(1));
    if (size == '0) begin
      return '0;
    end else if (b < half) begin
      return b + VAL_W'(1) - span;
    end else begin
      return b;
    end
  endfunction

endpackage

// File: hdl/jcrd_ctrl.sv
// Controller for the coefficient run decoder: takes an item, then sequences
// one result beat per free output slot. Depends on jcrd_pkg.
module jcrd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  jcrd_pkg::jcrd_sts_t sts,
  output jcrd_pkg::jcrd_cmd_t cmd
);
  import jcrd_pkg::*;

  jcrd_state_t state;
  jcrd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.step_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/jcrd_dpath.sv
// Datapath for the coefficient run decoder: item registers, block position,
// DC predictors, value extension and the output register. Depends on jcrd_pkg.
module jcrd_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  jcrd_pkg::jcrd_cmd_t        cmd,
  output jcrd_pkg::jcrd_sts_t        sts,
  input  logic [jcrd_pkg::COMP_W-1:0] component,
  input  logic [jcrd_pkg::SYM_W-1:0]  symbol,
  input  logic [jcrd_pkg::BITS_W-1:0] extra_bits,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [jcrd_pkg::VAL_W-1:0] coef_value,
  output logic [jcrd_pkg::POS_W-1:0] coef_index,
  output logic                       block_done,
  output logic                       run_last,
  output logic                       overrun_error
);
  import jcrd_pkg::*;

  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  position_next;
  logic [NIB_W-1:0]  run_left;
  logic [NIB_W-1:0]  run_left_next;
  logic [VAL_W-1:0]  dc_pred [NUM_COMPONENTS];
  logic [COMP_W-1:0] comp_r;
  logic [COMP_W-1:0] pred_sel;
  logic [NIB_W-1:0]  size_r;
  logic [BITS_W-1:0] bits_r;
  jcrd_kind_t        kind;
  jcrd_kind_t        kind_next;
  logic [POS_W:0]    run_end;
  logic [VAL_W-1:0]  ext;
  logic [VAL_W-1:0]  dc_sum;
  logic              at_last;
  logic [VAL_W-1:0]  val_next;
  logic [POS_W-1:0]  idx_next;
  logic              done_next;
  logic              last_next;
  logic              err_next;

  // classify on intake
  assign run_end = {1'b0, position} + {{(POS_W + 1 - NIB_W){1'b0}}, symbol[7:4]};

  always_comb begin
    priority if (position == '0) begin
      kind_next = KIND_DC;
    end else if (symbol == '0) begin
      kind_next = KIND_EOB;
    end else if (run_end > {1'b0, LAST_POS}) begin
      kind_next = KIND_OVR;
    end else begin
      kind_next = KIND_AC;
    end
  end

  assign pred_sel = COMP_W'(comp_r % NUM_COMPONENTS);
  assign ext      = jcrd_extend(size_r, bits_r);
  assign dc_sum   = dc_pred[pred_sel] + ext;
  assign at_last  = (position == LAST_POS);

  always_comb begin
    sts.out_free  = !out_valid || !out_stall;
    val_next      = '0;
    idx_next      = position;
    done_next     = at_last;
    last_next     = at_last;
    err_next      = 1'b0;
    position_next = at_last ? '0 : position + POS_W'(1);
    run_left_next = run_left;
    sts.step_last = at_last;
    unique case (kind)
      KIND_DC: begin
        val_next      = dc_sum;
        idx_next      = '0;
        done_next     = 1'b0;
        last_next     = 1'b1;
        position_next = POS_W'(1);
        sts.step_last = 1'b1;
      end
      KIND_EOB: begin
      end
      KIND_OVR: begin
        err_next = at_last;
      end
      KIND_AC: begin
        if (run_left != '0) begin
          done_next     = 1'b0;
          last_next     = 1'b0;
          run_left_next = run_left - NIB_W'(1);
          sts.step_last = 1'b0;
        end else begin
          val_next      = ext;
          last_next     = 1'b1;
          sts.step_last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        dc_pred[i] <= '0;
      end
    end else begin
      if (cmd.emit) begin
        position  <= position_next;
        out_valid <= 1'b1;
        if (kind == KIND_DC) begin
          dc_pred[pred_sel] <= dc_sum;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      comp_r   <= component;
      kind     <= kind_next;
      run_left <= symbol[7:4];
      size_r   <= (kind_next == KIND_DC && symbol[7:4] != '0) ? MAX_SIZE : symbol[3:0];
      bits_r   <= extra_bits;
    end else if (cmd.emit) begin
      run_left <= run_left_next;
    end
    if (cmd.emit) begin
      coef_value    <= val_next;
      coef_index    <= idx_next;
      block_done    <= done_next;
      run_last      <= last_next;
      overrun_error <= err_next;
    end
  end

  a_done_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_done) |-> (coef_index == LAST_POS && run_last))
    else $error("block end away from last position");

  a_err_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overrun_error) |-> (block_done && coef_value == '0))
    else $error("overrun flag on a non-final or nonzero beat");

  a_dc_advance: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && kind == KIND_DC) |=> (position == POS_W'(1)))
    else $error("position not one after DC");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(coef_index) && out_valid)
    else $error("stalled result overwritten");

endmodule

// File: hdl/jpeg_coefficient_run_decoder_core.sv
// Top level of the coefficient run decoder: controller plus datapath.
// Depends on jcrd_pkg, jcrd_ctrl, jcrd_dpath.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | component, symbol, extra_bits
//  out     | out_valid / out_stall| coef_value, coef_index, block_done,
//          |                      | run_last, overrun_error
//
// An item is taken in ST_IDLE, then in ST_EMIT its results go one beat per
// cycle into the output register while that register is free; a DC or plain
// AC item with no zero run gives a single beat. in_stall stays high until
// the item's last beat is in the output register, which may still wait while
// the next item is taken. out_stall freezes a valid output register and
// pauses the sequencing. Reset clears block position and the DC predictors.
module jpeg_coefficient_run_decoder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [jcrd_pkg::COMP_W-1:0] component,
  input  logic [jcrd_pkg::SYM_W-1:0]  symbol,
  input  logic [jcrd_pkg::BITS_W-1:0] extra_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [jcrd_pkg::VAL_W-1:0] coef_value,
  output logic [jcrd_pkg::POS_W-1:0]  coef_index,
  output logic                        block_done,
  output logic                        run_last,
  output logic                        overrun_error
);
  import jcrd_pkg::*;

  jcrd_cmd_t cmd;
  jcrd_sts_t sts;

  jcrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  jcrd_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .component     (component),
    .symbol        (symbol),
    .extra_bits    (extra_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .coef_value    (coef_value),
    .coef_index    (coef_index),
    .block_done    (block_done),
    .run_last      (run_last),
    .overrun_error (overrun_error)
  );

endmodule
